[sv/arc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the ARP responder cache.
package arc_pkg;

   // Command codes carried on the request tuser.
   localparam logic [1:0] CMD_PACKET = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_LOCAL_IP  = 1'b0;
   localparam logic CSR_LOCAL_MAC = 1'b1;

   // Accepted ARP header values.
   localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
   localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
   localparam logic [7:0]  HLEN_MAC       = 8'd6;
   localparam logic [7:0]  PLEN_IPV4      = 8'd4;
   localparam logic [15:0] OPCODE_REQUEST = 16'h0001;

   // Entry index width; covers the largest supported cache of 256 entries.
   localparam int ARC_IDX_W = 8;

   // Search token that walks down the row of cells.
   typedef struct packed {
      logic                 valid;
      logic [31:0]          key;
      logic                 hit;
      logic [ARC_IDX_W-1:0] hit_idx;
      logic [47:0]          hit_mac;
      logic                 free;
      logic [ARC_IDX_W-1:0] free_idx;
   } arc_token_type;

   // Write and clear command broadcast to every cell.
   typedef struct packed {
      logic                 en;
      logic                 clear;
      logic [ARC_IDX_W-1:0] idx;
      logic [31:0]          ip;
      logic [47:0]          mac;
   } arc_write_type;

endpackage

[sv/arc_cell.sv]
`timescale 1ns / 1ps
// One cache entry cell: holds an entry and updates the passing search token.
module arc_cell
   import arc_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  arc_token_type tok_in,
   output arc_token_type tok_out,
   input  arc_write_type wr
);

   logic          valid_ff;
   logic          valid_in;
   logic [31:0]   ip_ff;
   logic [47:0]   mac_ff;
   arc_token_type tok_ff;
   arc_token_type tok_in_upd;
   logic          wr_here;

   assign wr_here = wr.en && (wr.idx == ARC_IDX_W'(CELL_INDEX));

   // Entry valid bit: cleared by reset or a cache clear, set by a write.
   always_comb begin
      valid_in = valid_ff;
      if (wr.clear) begin
         valid_in = 1'b0;
      end else if (wr_here) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Entry contents are written only by a targeted write.
   always_ff @(posedge clock) begin
      if (wr_here) begin
         ip_ff  <= wr.ip;
         mac_ff <= wr.mac;
      end
   end

   // The first match and the first free entry along the row win.
   always_comb begin
      tok_in_upd = tok_in;
      if (!tok_in.hit && valid_ff && (ip_ff == tok_in.key)) begin
         tok_in_upd.hit     = 1'b1;
         tok_in_upd.hit_idx = ARC_IDX_W'(CELL_INDEX);
         tok_in_upd.hit_mac = mac_ff;
      end
      if (!tok_in.free && !valid_ff) begin
         tok_in_upd.free     = 1'b1;
         tok_in_upd.free_idx = ARC_IDX_W'(CELL_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_upd;
      end
   end

   assign tok_out = tok_ff;

endmodule

[sv/arp_responder_cache_core.sv]
`timescale 1ns / 1ps
// ARP responder with an IPv4-to-MAC cache built as a row of entry cells.
// The search token moves one cell per cycle through the row of ENTRIES cells;
// a new request is taken only after the previous result has moved to the
// output register, where a finished word may wait while the next request is
// taken.
// Reset (synchronous, active high) clears all valid bits, the control state
// and both configuration registers.
module arp_responder_cache_core
   import arc_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: htype[15:0], ptype[31:16], hlen[39:32], plen[47:40],
   // opcode[63:48], sender_mac[111:64], sender_ip[143:112], tgt_ip[175:144]
   input  logic [175:0] req_tdata,
   // tuser: cmd[1:0]
   input  logic [1:0]   req_tuser,
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: status[1:0], send_reply[2], reply_dest_mac[50:3],
   // reply_dest_ip[82:51], lookup_hit[83], lookup_mac[131:84], zero[135:132]
   output logic [135:0] rsp_tdata,
   // Configuration write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [47:0]  csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]   state_ff, state_in;
   logic [31:0]  local_ip_ff;
   logic [47:0]  local_mac_ff;

   // Captured request.
   logic [1:0]   cmd_ff;
   logic [15:0]  htype_ff, ptype_ff, opcode_ff;
   logic [7:0]   hlen_ff, plen_ff;
   logic [47:0]  smac_ff;
   logic [31:0]  sip_ff, tip_ff;
   logic         launch_ff;

   // Pending result and output register.
   logic [131:0] res_ff, res_in;
   logic [135:0] rsp_data_ff;
   logic         rsp_valid_ff;

   arc_token_type tok [0:ENTRIES];
   arc_write_type wr;

   logic req_fire;
   logic finish;
   logic rsp_load;
   logic fmt_ok;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign finish     = (state_ff == ST_SCAN) && tok[ENTRIES].valid;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff  <= '0;
         local_mac_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOCAL_IP:  local_ip_ff  <= csr_data[31:0];
            CSR_LOCAL_MAC: local_mac_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff    <= req_tuser;
         htype_ff  <= req_tdata[15:0];
         ptype_ff  <= req_tdata[31:16];
         hlen_ff   <= req_tdata[39:32];
         plen_ff   <= req_tdata[47:40];
         opcode_ff <= req_tdata[63:48];
         smac_ff   <= req_tdata[111:64];
         sip_ff    <= req_tdata[143:112];
         tip_ff    <= req_tdata[175:144];
      end
   end

   // Sequencer state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_SCAN;
         ST_SCAN: if (finish) state_in = ST_DONE;
         ST_DONE: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         launch_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= req_fire;
      end
   end

   // Token entering the first cell: lookups search the target, packets the sender.
   always_comb begin
      tok[0]       = '0;
      tok[0].valid = launch_ff;
      tok[0].key   = (cmd_ff == CMD_LOOKUP) ? tip_ff : sip_ff;
   end

   // Row of entry cells.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      arc_cell #(
         .CELL_INDEX(g)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_in (tok[g]),
         .tok_out(tok[g+1]),
         .wr     (wr)
      );
   end

   assign fmt_ok = (htype_ff == HTYPE_ETHERNET) && (ptype_ff == PTYPE_IPV4) &&
                   (hlen_ff == HLEN_MAC) && (plen_ff == PLEN_IPV4);

   // Decision at the end of the scan: cache update and result word.
   always_comb begin
      logic [1:0]  status;
      logic        send;
      logic [47:0] dmac;
      logic [31:0] dip;
      logic        hit;
      logic [47:0] lmac;
      status   = STATUS_OK;
      send     = 1'b0;
      dmac     = '0;
      dip      = '0;
      hit      = 1'b0;
      lmac     = '0;
      wr       = '0;
      wr.ip    = sip_ff;
      wr.mac   = smac_ff;
      wr.idx   = tok[ENTRIES].hit ? tok[ENTRIES].hit_idx : tok[ENTRIES].free_idx;
      case (cmd_ff)
         CMD_PACKET: begin
            if (!fmt_ok) begin
               status = STATUS_REJECT;
            end else begin
               if (tok[ENTRIES].hit || tok[ENTRIES].free) begin
                  wr.en = finish;
               end else begin
                  status = STATUS_FULL;
               end
               if ((opcode_ff == OPCODE_REQUEST) && (tip_ff == local_ip_ff)) begin
                  send = 1'b1;
                  dmac = smac_ff;
                  dip  = sip_ff;
               end
            end
         end
         CMD_LOOKUP: begin
            hit  = tok[ENTRIES].hit;
            lmac = tok[ENTRIES].hit ? tok[ENTRIES].hit_mac : 48'd0;
         end
         CMD_CLEAR: begin
            wr.clear = finish;
         end
         default: ;
      endcase
      res_in = {lmac, hit, dip, dmac, send, status};
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         res_ff <= res_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {4'b0000, res_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The local MAC is the sender address of the outgoing reply frame, which is
   // built downstream; it is stored here but not driven to any port.
   logic unused_mac;
   assign unused_mac = ^local_mac_ff;

endmodule
